// ===== rtl/mat_pkg.sv =====
// Shared types, constants and codes for the match-action table lookup block.
package mat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Transport protocol numbers
  localparam logic [7:0] NH_TCP = 8'd6;
  localparam logic [7:0] NH_UDP = 8'd17;

  // Commands
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Action codes
  localparam logic [1:0] ACT_SWITCH = 2'd0;
  localparam logic [1:0] ACT_ROUTE  = 2'd1;
  localparam logic [1:0] ACT_NAT    = 2'd2;
  localparam logic [1:0] ACT_DROP   = 2'd3;

  // Register indexes (byte address = 8 * index)
  localparam int PADDR_W = 5;
  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_DEFPORT = 2'd1;
  localparam logic [1:0] REG_NAT_HI  = 2'd2;
  localparam logic [1:0] REG_NAT_LO  = 2'd3;

  // Register reset values
  localparam logic [4:0]  ACTIVE_RST  = 5'd0;
  localparam logic [7:0]  DEFPORT_RST = 8'd55;
  localparam logic [63:0] NAT_RST     = 64'h0457_0457_0457_0457;

  typedef struct packed {
    logic        command;
    logic [3:0]  entry_index;
    logic [47:0] dest_mac;
    logic [63:0] dest_ip_hi;
    logic [63:0] dest_ip_lo;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [7:0]  next_header;
    logic [15:0] src_port;
    logic [7:0]  out_port;
    logic [7:0]  hop_limit;
  } mat_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  egress_port;
    logic [63:0] new_src_hi;
    logic [63:0] new_src_lo;
    logic [7:0]  hop_limit_out;
    logic        unknown_transport;
  } mat_out_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [15:0] port_block;
    logic [7:0]  egress;
  } mat_entry_t;

  // Compare unit verdict for one entry
  typedef struct packed {
    logic       hit;
    logic [1:0] action;
    logic [7:0] egress;
  } mat_hit_t;

endpackage

// ===== rtl/mat_table.sv =====
// Match-action entry memory: one write port, one registered read port.
module mat_table (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [mat_pkg::IDX_W-1:0] wr_addr,
  input  mat_pkg::mat_entry_t      wr_data,
  input  logic                     rd_en,
  input  logic [mat_pkg::IDX_W-1:0] rd_addr,
  output mat_pkg::mat_entry_t      rd_data
);

  mat_pkg::mat_entry_t mem_r [mat_pkg::TABLE_DEPTH];
  mat_pkg::mat_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mat_match.sv =====
// Shared compare unit: checks one table entry against the packet in priority order.
module mat_match (
  input  mat_pkg::mat_entry_t entry,
  input  mat_pkg::mat_in_t    pkt,
  input  logic [15:0]         pkt_port,
  output mat_pkg::mat_hit_t   verdict
);

  logic mac_eq;
  logic dst_eq;
  logic src_eq;
  logic port_eq;

  assign mac_eq  = (entry.mac == pkt.dest_mac);
  assign dst_eq  = (entry.dst_hi == pkt.dest_ip_hi) && (entry.dst_lo == pkt.dest_ip_lo);
  assign src_eq  = (entry.src_hi == pkt.src_ip_hi) && (entry.src_lo == pkt.src_ip_lo);
  assign port_eq = (entry.port_block == pkt_port);

  always_comb begin
    verdict.hit    = 1'b1;
    verdict.action = mat_pkg::ACT_DROP;
    verdict.egress = 8'd0;
    if (mac_eq) begin
      verdict.action = mat_pkg::ACT_SWITCH;
      verdict.egress = entry.egress;
    end else if (dst_eq) begin
      verdict.action = mat_pkg::ACT_ROUTE;
      verdict.egress = entry.egress;
    end else if (src_eq) begin
      verdict.action = mat_pkg::ACT_NAT;
    end else if (!port_eq) begin
      verdict.hit = 1'b0;
    end
  end

endmodule

// ===== rtl/match_action_table_lookup.sv =====
// Top level of the match-action table lookup: sequencer, config registers, result register.
//
//   channel  direction  handshake                  payload
//   in_      input      in_valid / in_ready         mat_in_t  (lookup or table write)
//   out_     output     out_valid / out_ready       mat_out_t (one per lookup)
//   cfg      input      APB psel/penable/pwrite     64-bit registers at 8*index
//
// A write command stores the entry at the accept edge and makes
// no result; in_ready stays high.
// A lookup scans one entry per cycle through the single compare unit; the
// table read is registered, so each entry is compared once its read data
// arrives. The scan stops at the first hit, or when nothing hits after
// min(active_entries, TABLE_DEPTH) entries, and the result then moves from
// the result register to the output register.
// The output register frees the scan: a new item is accepted while the
// previous result still waits on out_ready. A result waiting for that
// register holds the sequencer in its final state.
// Reset (rst_n low, synchronous) clears control registers and sets config
// registers to their reset values; the table holds no valid state and is undefined until written.
module match_action_table_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mat_pkg::mat_in_t               in_item,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output mat_pkg::mat_out_t              out_item,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mat_pkg::PADDR_W-1:0]    paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;

  // config registers
  logic [4:0]                   cfg_active_r;
  logic [7:0]                   cfg_defport_r;
  logic [63:0]                  cfg_nat_hi_r;
  logic [63:0]                  cfg_nat_lo_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  // packet context of the lookup in flight
  mat_pkg::mat_in_t             pkt_r;
  logic                         known_r;
  logic [15:0]                  pport_r;
  logic [mat_pkg::CNT_W-1:0]    cnt_r;

  // scan control
  logic [mat_pkg::CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         last_r, last_nxt;
  logic                         rd_en;

  // results
  mat_pkg::mat_out_t            res_r, res_nxt;
  logic                         out_valid_r;
  mat_pkg::mat_out_t            out_r;

  logic                         accept;
  logic                         is_write;
  logic                         known_in;
  logic [mat_pkg::CNT_W-1:0]    cnt_in;
  logic                         out_free;

  mat_pkg::mat_entry_t          wr_entry;
  mat_pkg::mat_entry_t          rd_entry;
  mat_pkg::mat_hit_t            verdict;

  // Result assembly from an action decision and the stored packet.
  function automatic mat_pkg::mat_out_t make_res(
    input logic [1:0]        act,
    input logic [7:0]        egr,
    input mat_pkg::mat_in_t  pkt,
    input logic              known,
    input logic [63:0]       nat_hi,
    input logic [63:0]       nat_lo
  );
    mat_pkg::mat_out_t r;
    r.action            = act;
    r.egress_port       = egr;
    r.new_src_hi        = (act == mat_pkg::ACT_NAT) ? nat_hi : pkt.src_ip_hi;
    r.new_src_lo        = (act == mat_pkg::ACT_NAT) ? nat_lo : pkt.src_ip_lo;
    // switch and route forward the packet, so the hop limit drops (wraps at 0)
    r.hop_limit_out     = ((act == mat_pkg::ACT_SWITCH) || (act == mat_pkg::ACT_ROUTE)) ?
                          (pkt.hop_limit - 8'd1) : pkt.hop_limit;
    r.unknown_transport = !known;
    return r;
  endfunction

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[mat_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r  <= mat_pkg::ACTIVE_RST;
      cfg_defport_r <= mat_pkg::DEFPORT_RST;
      cfg_nat_hi_r  <= mat_pkg::NAT_RST;
      cfg_nat_lo_r  <= mat_pkg::NAT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mat_pkg::REG_ACTIVE:  cfg_active_r  <= pwdata[4:0];
        mat_pkg::REG_DEFPORT: cfg_defport_r <= pwdata[7:0];
        mat_pkg::REG_NAT_HI:  cfg_nat_hi_r  <= pwdata;
        mat_pkg::REG_NAT_LO:  cfg_nat_lo_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mat_pkg::REG_ACTIVE:  prdata = {59'd0, cfg_active_r};
      mat_pkg::REG_DEFPORT: prdata = {56'd0, cfg_defport_r};
      mat_pkg::REG_NAT_HI:  prdata = cfg_nat_hi_r;
      mat_pkg::REG_NAT_LO:  prdata = cfg_nat_lo_r;
      default:              prdata = 64'd0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_write = (in_item.command == mat_pkg::CMD_WRITE);
  assign known_in = (in_item.next_header == mat_pkg::NH_TCP) ||
                    (in_item.next_header == mat_pkg::NH_UDP);

  // active count clamps to the table depth
  always_comb begin
    if (32'(cfg_active_r) > mat_pkg::TABLE_DEPTH) begin
      cnt_in = mat_pkg::CNT_W'(mat_pkg::TABLE_DEPTH);
    end else begin
      cnt_in = mat_pkg::CNT_W'(cfg_active_r);
    end
  end

  assign wr_entry.mac        = in_item.dest_mac;
  assign wr_entry.dst_hi     = in_item.dest_ip_hi;
  assign wr_entry.dst_lo     = in_item.dest_ip_lo;
  assign wr_entry.src_hi     = in_item.src_ip_hi;
  assign wr_entry.src_lo     = in_item.src_ip_lo;
  assign wr_entry.port_block = in_item.src_port;
  assign wr_entry.egress     = in_item.out_port;

  // ---------------------------------------------------------------- table + compare
  assign rd_en = (state_r == ST_SCAN) && (rd_idx_r < cnt_r);

  mat_table u_table (
    .clk     (clk),
    .wr_en   (accept && is_write && (32'(in_item.entry_index) < mat_pkg::TABLE_DEPTH)),
    .wr_addr (mat_pkg::IDX_W'(in_item.entry_index)),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[mat_pkg::IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  mat_match u_match (
    .entry    (rd_entry),
    .pkt      (pkt_r),
    .pkt_port (pport_r),
    .verdict  (verdict)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    last_nxt   = last_r;
    res_nxt    = res_r;
    case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (accept && !is_write) begin
          if (cnt_in == '0) begin
            // empty table scan: straight to the default route
            res_nxt   = make_res(mat_pkg::ACT_ROUTE, cfg_defport_r, in_item, known_in,
                                 cfg_nat_hi_r, cfg_nat_lo_r);
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + mat_pkg::CNT_W'(1);
          rd_vld_nxt = 1'b1;
          last_nxt   = ((rd_idx_r + mat_pkg::CNT_W'(1)) == cnt_r);
        end
        if (rd_vld_r) begin
          if (verdict.hit) begin
            res_nxt    = make_res(verdict.action, verdict.egress, pkt_r, known_r,
                                  cfg_nat_hi_r, cfg_nat_lo_r);
            state_nxt  = ST_DONE;
            rd_vld_nxt = 1'b0;
          end else if (last_r) begin
            res_nxt    = make_res(mat_pkg::ACT_ROUTE, cfg_defport_r, pkt_r, known_r,
                                  cfg_nat_hi_r, cfg_nat_lo_r);
            state_nxt  = ST_DONE;
            rd_vld_nxt = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      last_r   <= last_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept && !is_write) begin
      pkt_r   <= in_item;
      known_r <= known_in;
      pport_r <= known_in ? in_item.src_port : 16'd0;
      cnt_r   <= cnt_in;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---------------------------------------------------------------- assertions
  a_rd_vld_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("compare data valid outside of a scan");

  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= cnt_r))
    else $error("scan read index ran past the active count");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_write) |=> (state_r == ST_IDLE))
    else $error("table write left the idle state");

  a_empty_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_write && (cfg_active_r == 5'd0)) |=> (state_r == ST_DONE))
    else $error("lookup with no active entries did not finish at once");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished lookup did not reach the output register");

endmodule
